[sv/tls_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_pkg
// Shared widths, codes and types of the tridiagonal line solver.
// ----------------------------------------------------------------------------
package tls_pkg;

  localparam int DATA_W    = 32;   // Q4.28 word
  localparam int Q_FRAC    = 28;   // fraction bits
  localparam int POS_W     = 6;    // position field
  localparam int WIDE_W    = 36;   // sweep numerator / denominator after the shift
  localparam int PROD_W    = 64;   // full product of two words
  localparam int SUM_W     = 65;   // product plus shifted word, no wrap
  localparam int CFG_IDX_W = 3;
  localparam int NUM_LANES = 2;    // quotients per divider pass
  localparam int Q_ITER    = 32;   // quotient bits per pass

  localparam logic signed [DATA_W-1:0] ONE_Q = 32'sh1000_0000;
  localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_LOWER    = 3'd0,
    CFG_COEF_DIAG     = 3'd1,
    CFG_COEF_UPPER    = 3'd2,
    CFG_LEFT_BOUNDARY = 3'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_LOAD,
    ST_DIV_WAIT,
    ST_END_RD,
    ST_XDIV_LOAD,
    ST_XDIV_WAIT,
    ST_EMIT_X,
    ST_BS_MUL,
    ST_BS_SUM,
    ST_BS_EMIT,
    ST_BS_RD
  } state_t;

  typedef struct packed {
    logic                                start;
    logic [NUM_LANES-1:0][WIDE_W-1:0]    num;
    logic [WIDE_W-1:0]                   den;
  } div_req_t;

  typedef struct packed {
    logic                                done;
    logic [NUM_LANES-1:0]                sat;
    logic [NUM_LANES-1:0][DATA_W-1:0]    q;
  } div_res_t;

endpackage

[sv/tls_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/tls_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_div
// Radix-2 restoring divider, two numerators over one shared denominator.
// Gives saturated Q4.28 quotients (num * 2^28) / den, truncated toward zero.
// ----------------------------------------------------------------------------
module tls_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tls_pkg::div_req_t  req,
  output tls_pkg::div_res_t  res
);
  import tls_pkg::*;

  localparam int CNT_W = $clog2(Q_ITER);
  localparam int HI_SH = DATA_W - Q_FRAC;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [WIDE_W-1:0] vmag_r;
  logic             dzero_r;
  logic [WIDE_W-1:0] rem_r  [NUM_LANES];
  logic [DATA_W-1:0] dlo_r  [NUM_LANES];
  logic [DATA_W-1:0] quo_r  [NUM_LANES];
  logic [NUM_LANES-1:0] neg_r, nneg_r, big_r;

  logic [WIDE_W-1:0] vmag;
  logic [WIDE_W-1:0] nmag   [NUM_LANES];
  logic [WIDE_W:0]   trial  [NUM_LANES];
  logic [WIDE_W:0]   diff   [NUM_LANES];
  logic [NUM_LANES-1:0] ge;

  always_comb begin
    vmag = req.den[WIDE_W-1] ? (~req.den + 1'b1) : req.den;
    for (int l = 0; l < NUM_LANES; l++) begin
      nmag[l]  = req.num[l][WIDE_W-1] ? (~req.num[l] + 1'b1) : req.num[l];
      trial[l] = {rem_r[l], dlo_r[l][DATA_W-1]};
      diff[l]  = trial[l] - {1'b0, vmag_r};
      ge[l]    = trial[l] >= {1'b0, vmag_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(Q_ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      vmag_r  <= vmag;
      dzero_r <= (req.den == '0);
      for (int l = 0; l < NUM_LANES; l++) begin
        // quotient known to fit 32 bits only if the high dividend word is below the divisor
        rem_r[l]  <= WIDE_W'(nmag[l][WIDE_W-1:HI_SH]);
        dlo_r[l]  <= {nmag[l][HI_SH-1:0], {Q_FRAC{1'b0}}};
        quo_r[l]  <= '0;
        big_r[l]  <= WIDE_W'(nmag[l][WIDE_W-1:HI_SH]) >= vmag;
        nneg_r[l] <= req.num[l][WIDE_W-1];
        neg_r[l]  <= req.num[l][WIDE_W-1] ^ req.den[WIDE_W-1];
      end
    end else if (busy_r) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        rem_r[l] <= ge[l] ? diff[l][WIDE_W-1:0] : trial[l][WIDE_W-1:0];
        dlo_r[l] <= {dlo_r[l][DATA_W-2:0], 1'b0};
        quo_r[l] <= {quo_r[l][DATA_W-2:0], ge[l]};
      end
    end
  end

  always_comb begin
    res.done = done_r;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (dzero_r) begin
        res.sat[l] = 1'b1;
        res.q[l]   = nneg_r[l] ? S_MIN : S_MAX;
      end else if (big_r[l]) begin
        res.sat[l] = 1'b1;
        res.q[l]   = neg_r[l] ? S_MIN : S_MAX;
      end else if (neg_r[l]) begin
        res.sat[l] = quo_r[l][DATA_W-1] & (|quo_r[l][DATA_W-2:0]);
        res.q[l]   = res.sat[l] ? S_MIN : (~quo_r[l] + 1'b1);
      end else begin
        res.sat[l] = quo_r[l][DATA_W-1];
        res.q[l]   = res.sat[l] ? S_MAX : quo_r[l];
      end
    end
  end

endmodule

[sv/tridiagonal_line_solver_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tridiagonal_line_solver_top
// Thomas-algorithm solver for one line of a constant-coefficient tridiagonal
// system in signed Q4.28.
// ----------------------------------------------------------------------------
// Usage: program A, B, C and the left boundary over the cfg channel while idle.
// Send right-hand sides on the in channel, one transfer per row; in_line_end
// marks the last row. in_ready drops after each row transfer, so a row is
// taken only after the previous one has gone through two passes of the shared
// multiplier, the divider load, 32 steps of the two-lane restoring divider that
// forms alpha and beta together, and the store. Rows past LINE_LEN-2 are dropped.
// On the last row the block divides for the right end and then back-substitutes
// through the shared multiplier, one result per round of ST_BS_MUL, ST_BS_SUM,
// ST_BS_EMIT and ST_BS_RD, from position m+1 down to position 1 (out_last_result).
// Results sit in an output register: when out_ready is low the sequencer
// waits and nothing is lost. The next line may be sent while the final
// result still waits to be taken.
// Synchronous active-low reset clears the row count, the overflow flag, the
// output valid and restores the register reset values; the stores need none.
// ----------------------------------------------------------------------------
module tridiagonal_line_solver_top #(
  parameter int LINE_LEN = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [tls_pkg::DATA_W-1:0]    in_rhs_value,
  input  logic                                 in_line_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tls_pkg::DATA_W-1:0]    out_solution_value,
  output logic [tls_pkg::POS_W-1:0]            out_position,
  output logic                                 out_overflow,
  output logic                                 out_last_result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tls_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tls_pkg::DATA_W-1:0]           cfg_data
);
  import tls_pkg::*;

  localparam int AW = $clog2(LINE_LEN);
  localparam logic [AW-1:0] MAX_ROWS = AW'(LINE_LEN - 2);

  state_t state_r, state_nxt;

  logic signed [DATA_W-1:0] coef_lower_r, coef_diag_r, coef_upper_r, left_boundary_r;
  logic [AW-1:0] row_count_r, row_count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          ovf_r, ovf_nxt;
  logic          end_r, end_nxt;
  logic signed [DATA_W-1:0] rhs_r, rhs_nxt;
  logic signed [DATA_W-1:0] bp_r, bp_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic [WIDE_W-1:0]        den_r, den_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_en;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [POS_W-1:0]         out_pos_r, out_pos_nxt;
  logic                     out_ovf_r, out_ovf_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_load, out_free;

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic [DATA_W-1:0]        alpha_rd_u, beta_rd_u;
  logic signed [DATA_W-1:0] alpha_rd, beta_rd;
  logic [AW-1:0]            rd_addr;
  logic                     st_we;
  logic [AW-1:0]            st_waddr;

  logic signed [SUM_W-1:0]  den_sum, num_sum, bs_sum;
  logic [SUM_W-Q_FRAC-1:0]  bs_floor;
  logic signed [DATA_W-1:0] bs_sat;

  div_req_t div_req;
  div_res_t div_res;

  assign alpha_rd  = $signed(alpha_rd_u);
  assign beta_rd   = $signed(beta_rd_u);
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_solution_value = out_value_r;
  assign out_position       = out_pos_r;
  assign out_overflow       = out_ovf_r;
  assign out_last_result    = out_last_r;

  // forward sweep reads the previous row, back-substitution walks idx down
  assign rd_addr  = (state_r == ST_IDLE || state_r == ST_MUL_A) ? row_count_r : idx_r;
  assign st_waddr = AW'(row_count_r + 1'b1);

  tls_ram #(.WIDTH(DATA_W), .DEPTH(LINE_LEN)) u_alpha_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (div_res.q[0]),
    .raddr (rd_addr),
    .rdata (alpha_rd_u)
  );

  tls_ram #(.WIDTH(DATA_W), .DEPTH(LINE_LEN)) u_beta_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (div_res.q[1]),
    .raddr (rd_addr),
    .rdata (beta_rd_u)
  );

  tls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // shared multiplier operands
  always_comb begin
    unique case (state_r)
      ST_MUL_A: begin
        mul_a = coef_upper_r;
        mul_b = (row_count_r == '0) ? '0 : alpha_rd;
      end
      ST_MUL_B: begin
        mul_a = bp_r;
        mul_b = coef_upper_r;
      end
      default: begin
        mul_a = alpha_rd;
        mul_b = x_r;
      end
    endcase
  end

  // wide sums, floor by dropping fraction bits
  always_comb begin
    den_sum  = (SUM_W'(coef_diag_r) <<< Q_FRAC) + SUM_W'(prod_r);
    num_sum  = (SUM_W'(rhs_r) <<< Q_FRAC) - SUM_W'(prod_r);
    bs_sum   = SUM_W'(prod_r) + (SUM_W'(beta_rd) <<< Q_FRAC);
    bs_floor = bs_sum[SUM_W-1:Q_FRAC];
    if (bs_floor[SUM_W-Q_FRAC-1:DATA_W-1] == '0 ||
        bs_floor[SUM_W-Q_FRAC-1:DATA_W-1] == '1) begin
      bs_sat = $signed(bs_floor[DATA_W-1:0]);
    end else begin
      bs_sat = bs_floor[SUM_W-Q_FRAC-1] ? S_MIN : S_MAX;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    row_count_nxt = row_count_r;
    idx_nxt       = idx_r;
    ovf_nxt       = ovf_r;
    end_nxt       = end_r;
    rhs_nxt       = rhs_r;
    bp_nxt        = bp_r;
    x_nxt         = x_r;
    den_nxt       = den_r;
    prod_en       = 1'b0;
    st_we         = 1'b0;
    out_load      = 1'b0;
    out_value_nxt = out_value_r;
    out_pos_nxt   = out_pos_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = den_r;

    unique case (state_r)
      ST_IDLE: begin
        rhs_nxt = in_rhs_value;
        end_nxt = in_line_end;
        if (in_valid) begin
          if (row_count_r < MAX_ROWS) begin
            state_nxt = ST_MUL_A;
          end else if (in_line_end) begin
            idx_nxt   = row_count_r;
            state_nxt = ST_END_RD;
          end
        end
      end
      ST_MUL_A: begin
        prod_en   = 1'b1;
        bp_nxt    = (row_count_r == '0) ? left_boundary_r : beta_rd;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        den_nxt   = den_sum[Q_FRAC +: WIDE_W];
        prod_en   = 1'b1;
        state_nxt = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        div_req.start  = 1'b1;
        div_req.num[0] = -WIDE_W'(coef_lower_r);
        div_req.num[1] = num_sum[Q_FRAC +: WIDE_W];
        div_req.den    = den_r;
        state_nxt      = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_res.done) begin
          st_we         = 1'b1;
          ovf_nxt       = ovf_r | (|div_res.sat);
          row_count_nxt = st_waddr;
          idx_nxt       = st_waddr;
          state_nxt     = end_r ? ST_END_RD : ST_IDLE;
        end
      end
      ST_END_RD: begin
        if (idx_r == '0) begin
          row_count_nxt = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_XDIV_LOAD;
        end
      end
      ST_XDIV_LOAD: begin
        // right end: beta[m] / (1 - alpha[m]), second lane idles
        div_req.start  = 1'b1;
        div_req.num[0] = WIDE_W'(beta_rd);
        div_req.num[1] = '0;
        div_req.den    = WIDE_W'(ONE_Q) - WIDE_W'(alpha_rd);
        state_nxt      = ST_XDIV_WAIT;
      end
      ST_XDIV_WAIT: begin
        if (div_res.done) begin
          x_nxt     = $signed(div_res.q[0]);
          ovf_nxt   = ovf_r | div_res.sat[0];
          state_nxt = ST_EMIT_X;
        end
      end
      ST_EMIT_X: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_value_nxt = x_r;
          out_pos_nxt   = POS_W'(AW'(idx_r + 1'b1));
          out_ovf_nxt   = ovf_r;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_BS_MUL;
        end
      end
      ST_BS_MUL: begin
        prod_en   = 1'b1;
        state_nxt = ST_BS_SUM;
      end
      ST_BS_SUM: begin
        x_nxt     = bs_sat;
        state_nxt = ST_BS_EMIT;
      end
      ST_BS_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_value_nxt = x_r;
          out_pos_nxt   = POS_W'(idx_r);
          out_ovf_nxt   = ovf_r;
          out_last_nxt  = (idx_r == AW'(1));
          if (idx_r == AW'(1)) begin
            row_count_nxt = '0;
            ovf_nxt       = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = ST_BS_RD;
          end
        end
      end
      ST_BS_RD: begin
        // wait state for the registered store read
        state_nxt = ST_BS_MUL;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      row_count_r     <= '0;
      ovf_r           <= 1'b0;
      out_valid_r     <= 1'b0;
      coef_lower_r    <= '0;
      coef_diag_r     <= ONE_Q;
      coef_upper_r    <= '0;
      left_boundary_r <= ONE_Q;
    end else begin
      state_r     <= state_nxt;
      row_count_r <= row_count_nxt;
      ovf_r       <= ovf_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_COEF_LOWER:    coef_lower_r    <= $signed(cfg_data);
          CFG_COEF_DIAG:     coef_diag_r     <= $signed(cfg_data);
          CFG_COEF_UPPER:    coef_upper_r    <= $signed(cfg_data);
          CFG_LEFT_BOUNDARY: left_boundary_r <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    end_r       <= end_nxt;
    rhs_r       <= rhs_nxt;
    bp_r        <= bp_nxt;
    x_r         <= x_nxt;
    den_r       <= den_nxt;
    out_value_r <= out_value_nxt;
    out_pos_r   <= out_pos_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
    if (prod_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

endmodule

[sv/tls_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_checker
// Port-level checks of the tridiagonal line solver, bound to the top level.
// ----------------------------------------------------------------------------
module tls_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [tls_pkg::DATA_W-1:0] out_solution_value,
  input logic [tls_pkg::POS_W-1:0]         out_position,
  input logic                              out_overflow,
  input logic                              out_last_result
);
  import tls_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_solution_value) &&
    $stable(out_position))
    else $error("stalled result changed");

  // no new row is taken while a line is still being written out
  a_busy_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> !in_ready)
    else $error("input ready in the middle of a line's results");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |-> out_position == POS_W'(1))
    else $error("final result not at position 1");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position != '0)
    else $error("result at position 0");

  // overflow flag is one value for the whole line
  a_ovf_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_result |=>
    !out_valid || out_overflow == $past(out_overflow))
    else $error("overflow flag changed within a line");

endmodule

bind tridiagonal_line_solver_top tls_checker u_tls_checker (.*);
